// File: rtl/core/iqpu_pkg.sv
`default_nettype none

package iqpu_pkg;

  // sample format register codes; zero falls through to 24-bit handling
  typedef logic [1:0] fmt_t;
  localparam fmt_t FMT_8BIT  = 2'd1;
  localparam fmt_t FMT_16BIT = 2'd2;
  localparam fmt_t FMT_24BIT = 2'd3;

  // byte_position value meaning "next byte is the skipped header byte"
  localparam logic [2:0] POS_SKIP = 3'd7;

  // result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/iqpu_pair_assemble.sv
`default_nettype none

module iqpu_pair_assemble (
  input  iqpu_pkg::fmt_t      fmt,
  input  logic [39:0]         partial,
  input  logic [7:0]          last_byte,
  output logic [31:0]         i_word,
  output logic [31:0]         q_word
);
  import iqpu_pkg::*;

  logic [7:0] b [6];

  // gathered bytes fill the pair, the closing byte lands at the pair's last slot
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      b[k] = partial[8*k +: 8];
    end
    b[5] = 8'h00;
    case (fmt)
      FMT_8BIT:  b[1] = last_byte;
      FMT_16BIT: b[3] = last_byte;
      default:   b[5] = last_byte;
    endcase
  end

  always_comb begin
    case (fmt)
      FMT_8BIT: begin
        i_word = {{8{b[0][7]}}, b[0], 16'h0000};
        q_word = {{8{b[1][7]}}, b[1], 16'h0000};
      end
      FMT_16BIT: begin
        i_word = {b[1], b[0], 16'h0000};
        q_word = {b[3], b[2], 16'h0000};
      end
      default: begin
        i_word = {b[2], b[1], b[0], 8'h00};
        q_word = {b[5], b[4], b[3], 8'h00};
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/iq_packet_sample_unpacker_unit.sv
// Pipeline: an accepted item passes through the input register, then the result register.
// Throughput: one byte item per cycle; the result register only holds the input
//   stage while a result waits under result_stall.
// Reset: synchronous, active high on rst; clears pipeline valids, sequence
//   tracking and gather state, and loads sample_format with 24-bit mode.
`default_nettype none

module iq_packet_sample_unpacker_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration: sample format register
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  // input byte channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        result_kind,
  output logic signed [31:0] i_value,
  output logic signed [31:0] q_value,
  output logic [7:0]  lost_count
);
  import iqpu_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  fmt_t sample_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_24BIT;
    end else if (cfg_wr_en) begin
      sample_format <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_start;
  logic       out_free;   // result register can take a new value this cycle
  logic       advance;    // input register item is processed this cycle

  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_full && out_free;
  // input register is free when empty or its item moves on this cycle
  assign item_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      in_byte  <= data_byte;
      in_start <= packet_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Deframing state
  // ---------------------------------------------------------------------------
  logic [7:0]  last_sequence, last_sequence_next;
  logic        sequence_seen, sequence_seen_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [39:0] partial_sample, partial_sample_next;

  logic [31:0] pair_i, pair_q;

  iqpu_pair_assemble u_assemble (
    .fmt       (sample_format),
    .partial   (partial_sample),
    .last_byte (in_byte),
    .i_word    (pair_i),
    .q_word    (pair_q)
  );

  logic [7:0] expect_seq;
  logic [3:0] pair_len;
  logic       pair_done;
  logic       emit;
  logic       kind_next;
  logic [7:0] gap_next;

  assign expect_seq = last_sequence + 8'd1;

  always_comb begin
    case (sample_format)
      FMT_8BIT:  pair_len = 4'd2;
      FMT_16BIT: pair_len = 4'd4;
      default:   pair_len = 4'd6;
    endcase
  end

  // pair completes on the byte whose count reaches the pair length
  assign pair_done = ({1'b0, byte_position} + 4'd1) >= pair_len;

  always_comb begin
    last_sequence_next  = last_sequence;
    sequence_seen_next  = sequence_seen;
    byte_position_next  = byte_position;
    partial_sample_next = partial_sample;
    emit                = 1'b0;
    kind_next           = KIND_SAMPLE;
    gap_next            = 8'h00;

    if (in_start) begin
      // sequence byte: gap check, then arm the header skip
      emit                = sequence_seen && (in_byte != expect_seq);
      kind_next           = KIND_REPORT;
      gap_next            = in_byte - expect_seq;
      last_sequence_next  = in_byte;
      sequence_seen_next  = 1'b1;
      byte_position_next  = POS_SKIP;
      partial_sample_next = '0;
    end else if (!sequence_seen) begin
      // bytes before the first packet are dropped
    end else if (byte_position == POS_SKIP) begin
      byte_position_next  = 3'd0;
      partial_sample_next = '0;
    end else if (pair_done) begin
      emit                = 1'b1;
      byte_position_next  = 3'd0;
      partial_sample_next = '0;
    end else begin
      for (int k = 0; k < 5; k++) begin
        if (byte_position == 3'(k)) begin
          partial_sample_next[8*k +: 8] = in_byte;
        end
      end
      byte_position_next = byte_position + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence  <= 8'h00;
      sequence_seen  <= 1'b0;
      byte_position  <= 3'd0;
      partial_sample <= '0;
    end else if (advance) begin
      last_sequence  <= last_sequence_next;
      sequence_seen  <= sequence_seen_next;
      byte_position  <= byte_position_next;
      partial_sample <= partial_sample_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_kind <= kind_next;
      lost_count  <= (kind_next == KIND_REPORT) ? gap_next : 8'h00;
      i_value     <= (kind_next == KIND_REPORT) ? 32'sd0 : $signed(pair_i);
      q_value     <= (kind_next == KIND_REPORT) ? 32'sd0 : $signed(pair_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_report_zero_samples: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_REPORT) |-> (i_value == 32'sd0) && (q_value == 32'sd0))
    else $error("loss report carries nonzero sample values");

  a_sample_zero_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_SAMPLE) |-> (lost_count == 8'h00))
    else $error("sample result carries nonzero lost_count");

  a_no_result_before_packet: assert property (@(posedge clk) disable iff (rst)
    !sequence_seen |-> !result_valid)
    else $error("result produced before any packet was seen");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    byte_position != 3'd6)
    else $error("byte_position outside gather range");

endmodule

`default_nettype wire
